// ===== hdl/omni_wheel_drive_mixer_assert.svh =====
// Assertion macros shared by the omni wheel drive mixer checkers.
`ifndef OMNI_WHEEL_DRIVE_MIXER_ASSERT_SVH
`define OMNI_WHEEL_DRIVE_MIXER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define OWDM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("owdm: assertion failed");

// Implication with a fixed delay, disabled while reset is held.
`define OWDM_ASSERT_DLY(label, clk, rst_n, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("owdm: delayed assertion failed");

`endif

// ===== hdl/owdm_pkg.sv =====
// Shared constants and types of the omni wheel drive mixer.
`default_nettype none

package owdm_pkg;

    localparam int unsigned NUM_WHEELS = 4;

    // gear taps, unsigned Q1.8
    localparam int unsigned GEAR_W = 2;
    localparam int unsigned TAP_W  = 9;
    localparam logic [GEAR_W-1:0] GEAR_ZERO = 2'd0;
    localparam logic [GEAR_W-1:0] GEAR_LOW  = 2'd1;
    localparam logic [GEAR_W-1:0] GEAR_MID  = 2'd2;
    localparam logic [GEAR_W-1:0] GEAR_FULL = 2'd3;
    localparam logic [TAP_W-1:0]  TAP_LOW   = 9'd77;
    localparam logic [TAP_W-1:0]  TAP_MID   = 9'd128;
    localparam logic [TAP_W-1:0]  TAP_FULL  = 9'd256;

    // sqrt(2)/2 in Q0.16, wheel gain in Q8.8, product k in Q8.24
    localparam int unsigned COEF_W = 16;
    localparam int unsigned GAIN_W = 16;
    localparam int unsigned K_W    = COEF_W + GAIN_W;
    localparam logic [COEF_W-1:0] MIX_COEF = 16'd46341;

    // duty percent
    localparam int unsigned DUTY_W = 7;
    localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;

    // duty divider: quotient bits resolved per stage
    localparam int unsigned DIV_STEP   = 3;
    localparam int unsigned DIV_STAGES = (DUTY_W + DIV_STEP - 1) / DIV_STEP;

    // register stages from accept to result: front 2, scale 3, divider
    localparam int unsigned PIPE_DEPTH = 5 + DIV_STAGES;

    // bridge pin codes
    localparam int unsigned PINS_W = 2;
    localparam logic [PINS_W-1:0] PINS_FWD   = 2'd1;
    localparam logic [PINS_W-1:0] PINS_REV   = 2'd2;
    localparam logic [PINS_W-1:0] PINS_BRAKE = 2'd3;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_GEAR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FWD_LIM = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REV_LIM = 2'd3;

    // per-wheel status carried beside the data
    typedef struct packed {
        logic neg;
        logic zero;
    } t_wflags;

    function automatic logic [TAP_W-1:0] gear_tap(input logic [GEAR_W-1:0] gear);
        logic [TAP_W-1:0] tap;
        unique case (gear) inside
            GEAR_ZERO, GEAR_LOW: tap = TAP_LOW;
            GEAR_MID:            tap = TAP_MID;
            GEAR_FULL:           tap = TAP_FULL;
            default:             tap = TAP_LOW;
        endcase
        return tap;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/owdm_front.sv =====
// Front end: gear scaling of the velocity pair, wheel mixing and magnitude split.
`default_nettype none

module owdm_front #(
    parameter int unsigned VEL_BITS = 18
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic signed [VEL_BITS-1:0]             i_vel_x,
    input  logic signed [VEL_BITS-1:0]             i_vel_y,
    input  logic [owdm_pkg::TAP_W-1:0]             i_tap,
    output logic                                   o_valid,
    output logic [VEL_BITS+owdm_pkg::TAP_W-1:0]    o_mag [owdm_pkg::NUM_WHEELS],
    output logic                                   o_neg [owdm_pkg::NUM_WHEELS]
);
    import owdm_pkg::*;

    localparam int unsigned SX_W  = VEL_BITS + TAP_W;
    localparam int unsigned MIX_W = SX_W + 1;

    logic signed [SX_W-1:0]  vx_ext;
    logic signed [SX_W-1:0]  vy_ext;
    logic signed [SX_W-1:0]  tap_ext;
    logic signed [SX_W-1:0]  n_sx;
    logic signed [SX_W-1:0]  n_sy;
    logic signed [SX_W-1:0]  r_sx;
    logic signed [SX_W-1:0]  r_sy;
    logic                    r_v1;

    logic signed [MIX_W-1:0] sx_e;
    logic signed [MIX_W-1:0] sy_e;
    logic signed [MIX_W-1:0] mix   [NUM_WHEELS];
    logic [SX_W-1:0]         n_mag [NUM_WHEELS];
    logic [SX_W-1:0]         r_mag [NUM_WHEELS];
    logic                    n_neg [NUM_WHEELS];
    logic                    r_neg [NUM_WHEELS];
    logic                    r_v2;

    // stage 1: scale by gear tap (exact, Q.8)
    always_comb begin
        vx_ext  = SX_W'(i_vel_x);
        vy_ext  = SX_W'(i_vel_y);
        tap_ext = $signed(SX_W'(i_tap));
        n_sx    = vx_ext * tap_ext;
        n_sy    = vy_ext * tap_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sx <= n_sx;
        r_sy <= n_sy;
    end

    // stage 2: 45-degree mix, sign and magnitude
    always_comb begin
        sx_e   = MIX_W'(r_sx);
        sy_e   = MIX_W'(r_sy);
        mix[0] = sx_e - sy_e;
        mix[1] = -sx_e - sy_e;
        mix[2] = sy_e - sx_e;
        mix[3] = sx_e + sy_e;
        for (int w = 0; w < NUM_WHEELS; w++) begin
            n_neg[w] = mix[w][MIX_W-1];
            n_mag[w] = n_neg[w] ? SX_W'(-mix[w]) : SX_W'(mix[w]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;
        r_neg <= n_neg;
    end

    assign o_valid = r_v2;
    assign o_mag   = r_mag;
    assign o_neg   = r_neg;

endmodule

`default_nettype wire

// ===== hdl/owdm_scale.sv =====
// Wheel scaling: magnitude times coefficient and gain, rpm saturation, duty numerator.
`default_nettype none

module owdm_scale #(
    parameter int unsigned VEL_BITS = 18,
    parameter int unsigned RPM_BITS = 9
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    input  logic [VEL_BITS+owdm_pkg::TAP_W-1:0]         i_mag [owdm_pkg::NUM_WHEELS],
    input  logic                                        i_neg [owdm_pkg::NUM_WHEELS],
    input  logic [owdm_pkg::K_W-1:0]                    i_k,
    input  logic [owdm_pkg::NUM_WHEELS*RPM_BITS-1:0]    i_fwd_lim,
    input  logic [owdm_pkg::NUM_WHEELS*RPM_BITS-1:0]    i_rev_lim,
    output logic                                        o_valid,
    output owdm_pkg::t_wflags                           o_flags [owdm_pkg::NUM_WHEELS],
    output logic [RPM_BITS-1:0]                         o_q     [owdm_pkg::NUM_WHEELS],
    output logic [RPM_BITS-1:0]                         o_lim   [owdm_pkg::NUM_WHEELS],
    output logic [RPM_BITS+owdm_pkg::DUTY_W-1:0]        o_num   [owdm_pkg::NUM_WHEELS]
);
    import owdm_pkg::*;

    localparam int unsigned MAG_W  = VEL_BITS + TAP_W;
    localparam int unsigned LO_W   = MAG_W / 2;
    localparam int unsigned HI_W   = MAG_W - LO_W;
    localparam int unsigned PL_W   = LO_W + K_W;
    localparam int unsigned PH_W   = HI_W + K_W;
    localparam int unsigned PROD_W = MAG_W + K_W;
    localparam int unsigned NUM_W  = RPM_BITS + DUTY_W;

    // stage 3
    logic                r_v3;
    logic [PL_W-1:0]     n_plo  [NUM_WHEELS];
    logic [PL_W-1:0]     r_plo  [NUM_WHEELS];
    logic [PH_W-1:0]     n_phi  [NUM_WHEELS];
    logic [PH_W-1:0]     r_phi  [NUM_WHEELS];
    logic                r_neg3 [NUM_WHEELS];
    // stage 4
    logic                r_v4;
    logic [RPM_BITS-1:0] n_q4   [NUM_WHEELS];
    logic [RPM_BITS-1:0] r_q4   [NUM_WHEELS];
    logic [RPM_BITS-1:0] n_lim4 [NUM_WHEELS];
    logic [RPM_BITS-1:0] r_lim4 [NUM_WHEELS];
    logic                r_neg4 [NUM_WHEELS];
    // stage 5
    logic                r_v5;
    t_wflags             n_flg5 [NUM_WHEELS];
    t_wflags             r_flg5 [NUM_WHEELS];
    logic [NUM_W-1:0]    n_num5 [NUM_WHEELS];
    logic [NUM_W-1:0]    r_num5 [NUM_WHEELS];
    logic [RPM_BITS-1:0] r_q5   [NUM_WHEELS];
    logic [RPM_BITS-1:0] r_lim5 [NUM_WHEELS];

    // stage 3: two partial products, magnitude split in halves
    always_comb begin
        for (int w = 0; w < NUM_WHEELS; w++) begin
            n_plo[w] = PL_W'(i_mag[w][LO_W-1:0]) * PL_W'(i_k);
            n_phi[w] = PH_W'(i_mag[w][MAG_W-1:LO_W]) * PH_W'(i_k);
        end
    end

    // stage 4: recombine, drop 32 fraction bits, clamp to the limit of the direction
    always_comb begin
        for (int w = 0; w < NUM_WHEELS; w++) begin
            logic [PROD_W-1:0] full;
            logic [MAG_W-1:0]  qraw;
            full      = (PROD_W'(r_phi[w]) << LO_W) + PROD_W'(r_plo[w]);
            qraw      = full[PROD_W-1:K_W];
            n_lim4[w] = r_neg3[w] ? i_rev_lim[w*RPM_BITS +: RPM_BITS]
                                  : i_fwd_lim[w*RPM_BITS +: RPM_BITS];
            n_q4[w]   = (qraw > MAG_W'(n_lim4[w])) ? n_lim4[w] : qraw[RPM_BITS-1:0];
        end
    end

    // stage 5: duty numerator q * 100
    always_comb begin
        for (int w = 0; w < NUM_WHEELS; w++) begin
            n_num5[w]      = NUM_W'(r_q4[w]) * NUM_W'(DUTY_FULL);
            n_flg5[w].neg  = r_neg4[w];
            n_flg5[w].zero = (r_q4[w] == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v3 <= i_valid;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_plo  <= n_plo;
        r_phi  <= n_phi;
        r_neg3 <= i_neg;
        r_q4   <= n_q4;
        r_lim4 <= n_lim4;
        r_neg4 <= r_neg3;
        r_flg5 <= n_flg5;
        r_num5 <= n_num5;
        r_q5   <= r_q4;
        r_lim5 <= r_lim4;
    end

    assign o_valid = r_v5;
    assign o_flags = r_flg5;
    assign o_q     = r_q5;
    assign o_lim   = r_lim5;
    assign o_num   = r_num5;

endmodule

`default_nettype wire

// ===== hdl/owdm_duty_div.sv =====
// Pipelined restoring divider for the duty percent, plus final speed and pin coding.
`default_nettype none

module owdm_duty_div #(
    parameter int unsigned RPM_BITS = 9
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    input  owdm_pkg::t_wflags                       i_flags [owdm_pkg::NUM_WHEELS],
    input  logic [RPM_BITS-1:0]                     i_q     [owdm_pkg::NUM_WHEELS],
    input  logic [RPM_BITS-1:0]                     i_lim   [owdm_pkg::NUM_WHEELS],
    input  logic [RPM_BITS+owdm_pkg::DUTY_W-1:0]    i_num   [owdm_pkg::NUM_WHEELS],
    output logic                                    o_valid,
    output logic signed [RPM_BITS:0]                o_speed [owdm_pkg::NUM_WHEELS],
    output logic [owdm_pkg::DUTY_W-1:0]             o_duty  [owdm_pkg::NUM_WHEELS],
    output logic [owdm_pkg::PINS_W-1:0]             o_pins  [owdm_pkg::NUM_WHEELS]
);
    import owdm_pkg::*;

    localparam int unsigned NUM_W = RPM_BITS + DUTY_W;
    localparam int unsigned LAST  = DIV_STAGES - 1;

    logic                r_vld [DIV_STAGES];
    t_wflags             r_flg [DIV_STAGES][NUM_WHEELS];
    logic [RPM_BITS-1:0] r_q   [DIV_STAGES][NUM_WHEELS];
    logic [DUTY_W-1:0]   r_quo [DIV_STAGES][NUM_WHEELS];
    // remainder and divisor are not needed past the last stage
    logic [NUM_W-1:0]    r_rem [DIV_STAGES-1][NUM_WHEELS];
    logic [RPM_BITS-1:0] r_lim [DIV_STAGES-1][NUM_WHEELS];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        localparam int unsigned FIRST = s * DIV_STEP;
        localparam int unsigned NB    = (DUTY_W - FIRST < DIV_STEP) ? DUTY_W - FIRST : DIV_STEP;

        logic                v_in;
        t_wflags             flg_in [NUM_WHEELS];
        logic [RPM_BITS-1:0] q_in   [NUM_WHEELS];
        logic [RPM_BITS-1:0] lim_in [NUM_WHEELS];
        logic [NUM_W-1:0]    rem_in [NUM_WHEELS];
        logic [DUTY_W-1:0]   quo_in [NUM_WHEELS];
        logic [NUM_W-1:0]    n_rem  [NUM_WHEELS];
        logic [DUTY_W-1:0]   n_quo  [NUM_WHEELS];

        if (s == 0) begin : g_head
            always_comb begin
                v_in   = i_valid;
                flg_in = i_flags;
                q_in   = i_q;
                lim_in = i_lim;
                rem_in = i_num;
                for (int w = 0; w < NUM_WHEELS; w++) begin
                    quo_in[w] = '0;
                end
            end
        end else begin : g_body
            always_comb begin
                v_in   = r_vld[s-1];
                flg_in = r_flg[s-1];
                q_in   = r_q[s-1];
                lim_in = r_lim[s-1];
                rem_in = r_rem[s-1];
                quo_in = r_quo[s-1];
            end
        end

        // resolve NB quotient bits, most significant first
        always_comb begin
            for (int w = 0; w < NUM_WHEELS; w++) begin
                logic [NUM_W-1:0] sub;
                sub      = '0;
                n_rem[w] = rem_in[w];
                n_quo[w] = quo_in[w];
                for (int j = 0; j < NB; j++) begin
                    sub = NUM_W'(lim_in[w]) << (DUTY_W - 1 - (FIRST + j));
                    if (n_rem[w] >= sub) begin
                        n_rem[w] = n_rem[w] - sub;
                        n_quo[w][DUTY_W-1-(FIRST+j)] = 1'b1;
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_flg[s] <= flg_in;
            r_q[s]   <= q_in;
            r_quo[s] <= n_quo;
        end

        if (s < LAST) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[s] <= n_rem;
                r_lim[s] <= lim_in;
            end
        end
    end

    // final coding; a zero speed forces duty 0 (also covers a zero limit)
    always_comb begin
        for (int w = 0; w < NUM_WHEELS; w++) begin
            logic signed [RPM_BITS:0] spd;
            spd        = $signed({1'b0, r_q[LAST][w]});
            o_speed[w] = r_flg[LAST][w].neg ? -spd : spd;
            o_duty[w]  = r_flg[LAST][w].zero ? '0 : r_quo[LAST][w];
            if (r_flg[LAST][w].zero) begin
                o_pins[w] = PINS_BRAKE;
            end else if (r_flg[LAST][w].neg) begin
                o_pins[w] = PINS_REV;
            end else begin
                o_pins[w] = PINS_FWD;
            end
        end
    end

    assign o_valid = r_vld[LAST];

endmodule

`default_nettype wire

// ===== hdl/omni_wheel_drive_mixer.sv =====
// Top level of the omni wheel drive mixer: config registers and the wheel pipeline.
`default_nettype none

// Inverse kinematics for a four-wheel, 45-degree omni chassis.
// Input: raise start with a (vel_x, vel_y) pair; the item is taken at any
// rising edge where start is high and busy is low. busy stays low: the
// pipeline takes a new item every clock, one item per cycle sustained.
// Output: o_strobe is high for exactly one cycle with the four wheel speeds,
// duty percents and bridge pin codes. An item taken at an edge shows on the
// result ports after 8 register stages (gear scale, mix, split multiply,
// saturate, duty numerator, three divider stages).
// Results are in the order the items were taken. The receiver has no way to
// stall; every result is presented once and must be captured on its strobe.
// Config: a write on i_cfg_we lands at that edge: index 0 gear, 1 wheel gain
// (Q8.8), 2 forward rpm limits, 3 reverse rpm limits (wheel 0 in the low
// RPM_BITS). Write only while no item is in flight.
// Reset (synchronous, active low) flushes the pipeline valid bits and loads
// gear 1, gain 1.0 and the default rpm limits; no clearing pass is needed.
module omni_wheel_drive_mixer #(
    parameter int unsigned VEL_BITS = 18,
    parameter int unsigned RPM_BITS = 9
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        start,
    output logic                                        busy,
    input  logic signed [VEL_BITS-1:0]                  i_vel_x,
    input  logic signed [VEL_BITS-1:0]                  i_vel_y,
    input  logic                                        i_cfg_we,
    input  logic [owdm_pkg::CFG_IDX_W-1:0]              i_cfg_index,
    input  logic [owdm_pkg::NUM_WHEELS*RPM_BITS-1:0]    i_cfg_data,
    output logic                                        o_strobe,
    output logic signed [RPM_BITS:0]                    o_speed_w0,
    output logic signed [RPM_BITS:0]                    o_speed_w1,
    output logic signed [RPM_BITS:0]                    o_speed_w2,
    output logic signed [RPM_BITS:0]                    o_speed_w3,
    output logic [owdm_pkg::DUTY_W-1:0]                 o_duty_w0,
    output logic [owdm_pkg::DUTY_W-1:0]                 o_duty_w1,
    output logic [owdm_pkg::DUTY_W-1:0]                 o_duty_w2,
    output logic [owdm_pkg::DUTY_W-1:0]                 o_duty_w3,
    output logic [owdm_pkg::PINS_W-1:0]                 o_pins_w0,
    output logic [owdm_pkg::PINS_W-1:0]                 o_pins_w1,
    output logic [owdm_pkg::PINS_W-1:0]                 o_pins_w2,
    output logic [owdm_pkg::PINS_W-1:0]                 o_pins_w3
);
    import owdm_pkg::*;

    // the limit registers are the widest, so they set the data port width
    localparam int unsigned LIM_W = NUM_WHEELS * RPM_BITS;
    localparam int unsigned MAG_W = VEL_BITS + TAP_W;
    localparam int unsigned NUM_W = RPM_BITS + DUTY_W;

    // reset limits, wheel 0 in the low bits
    localparam logic [LIM_W-1:0] FWD_LIM_RST = {RPM_BITS'(345), RPM_BITS'(350),
                                                RPM_BITS'(360), RPM_BITS'(307)};
    localparam logic [LIM_W-1:0] REV_LIM_RST = {RPM_BITS'(345), RPM_BITS'(350),
                                                RPM_BITS'(360), RPM_BITS'(330)};
    localparam logic [GAIN_W-1:0] GAIN_RST = 16'd256;

    // configuration
    logic [GEAR_W-1:0] r_gear;
    logic [GAIN_W-1:0] r_gain;
    logic [LIM_W-1:0]  r_fwd_lim;
    logic [LIM_W-1:0]  r_rev_lim;
    logic [K_W-1:0]    r_k;

    // front -> scale
    logic              f_valid;
    logic [MAG_W-1:0]  f_mag [NUM_WHEELS];
    logic              f_neg [NUM_WHEELS];

    // scale -> divider
    logic                s_valid;
    t_wflags             s_flags [NUM_WHEELS];
    logic [RPM_BITS-1:0] s_q     [NUM_WHEELS];
    logic [RPM_BITS-1:0] s_lim   [NUM_WHEELS];
    logic [NUM_W-1:0]    s_num   [NUM_WHEELS];

    // divider -> ports
    logic signed [RPM_BITS:0] d_speed [NUM_WHEELS];
    logic [DUTY_W-1:0]        d_duty  [NUM_WHEELS];
    logic [PINS_W-1:0]        d_pins  [NUM_WHEELS];

    logic accept;

    // fully pipelined, never back-pressures
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gear    <= GEAR_LOW;
            r_gain    <= GAIN_RST;
            r_fwd_lim <= FWD_LIM_RST;
            r_rev_lim <= REV_LIM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_GEAR:    r_gear    <= i_cfg_data[GEAR_W-1:0];
                REG_GAIN:    r_gain    <= i_cfg_data[GAIN_W-1:0];
                REG_FWD_LIM: r_fwd_lim <= i_cfg_data;
                REG_REV_LIM: r_rev_lim <= i_cfg_data;
                default:     r_gear    <= r_gear;
            endcase
        end
    end

    // mix coefficient times gain, refreshed every cycle; a gain write is
    // visible here in the following cycle, well before an item reaches stage 3
    always_ff @(posedge i_clk) begin
        r_k <= K_W'(MIX_COEF) * K_W'(r_gain);
    end

    owdm_front #(
        .VEL_BITS (VEL_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_vel_x (i_vel_x),
        .i_vel_y (i_vel_y),
        .i_tap   (gear_tap(r_gear)),
        .o_valid (f_valid),
        .o_mag   (f_mag),
        .o_neg   (f_neg)
    );

    owdm_scale #(
        .VEL_BITS (VEL_BITS),
        .RPM_BITS (RPM_BITS)
    ) u_scale (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (f_valid),
        .i_mag     (f_mag),
        .i_neg     (f_neg),
        .i_k       (r_k),
        .i_fwd_lim (r_fwd_lim),
        .i_rev_lim (r_rev_lim),
        .o_valid   (s_valid),
        .o_flags   (s_flags),
        .o_q       (s_q),
        .o_lim     (s_lim),
        .o_num     (s_num)
    );

    owdm_duty_div #(
        .RPM_BITS (RPM_BITS)
    ) u_duty_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_valid),
        .i_flags (s_flags),
        .i_q     (s_q),
        .i_lim   (s_lim),
        .i_num   (s_num),
        .o_valid (o_strobe),
        .o_speed (d_speed),
        .o_duty  (d_duty),
        .o_pins  (d_pins)
    );

    assign o_speed_w0 = d_speed[0];
    assign o_speed_w1 = d_speed[1];
    assign o_speed_w2 = d_speed[2];
    assign o_speed_w3 = d_speed[3];
    assign o_duty_w0  = d_duty[0];
    assign o_duty_w1  = d_duty[1];
    assign o_duty_w2  = d_duty[2];
    assign o_duty_w3  = d_duty[3];
    assign o_pins_w0  = d_pins[0];
    assign o_pins_w1  = d_pins[1];
    assign o_pins_w2  = d_pins[2];
    assign o_pins_w3  = d_pins[3];

endmodule

`default_nettype wire

// ===== hdl/owdm_checker.sv =====
// Port-level assertion checker for the omni wheel drive mixer, with its bind.
`default_nettype none

`include "omni_wheel_drive_mixer_assert.svh"

module owdm_checker #(
    parameter int unsigned RPM_BITS = 9
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            i_busy,
    input  logic                            i_strobe,
    input  logic signed [RPM_BITS:0]        i_speed_w0,
    input  logic signed [RPM_BITS:0]        i_speed_w1,
    input  logic signed [RPM_BITS:0]        i_speed_w2,
    input  logic signed [RPM_BITS:0]        i_speed_w3,
    input  logic [owdm_pkg::DUTY_W-1:0]     i_duty_w0,
    input  logic [owdm_pkg::DUTY_W-1:0]     i_duty_w1,
    input  logic [owdm_pkg::DUTY_W-1:0]     i_duty_w2,
    input  logic [owdm_pkg::DUTY_W-1:0]     i_duty_w3,
    input  logic [owdm_pkg::PINS_W-1:0]     i_pins_w0,
    input  logic [owdm_pkg::PINS_W-1:0]     i_pins_w1,
    input  logic [owdm_pkg::PINS_W-1:0]     i_pins_w2,
    input  logic [owdm_pkg::PINS_W-1:0]     i_pins_w3
);
    import owdm_pkg::*;

    logic taken;
    logic brake_ok;
    logic duty_ok;

    assign taken = i_start && !i_busy;

    // brake code exactly when the speed is zero, on every wheel
    assign brake_ok = ((i_pins_w0 == PINS_BRAKE) == (i_speed_w0 == '0))
                   && ((i_pins_w1 == PINS_BRAKE) == (i_speed_w1 == '0))
                   && ((i_pins_w2 == PINS_BRAKE) == (i_speed_w2 == '0))
                   && ((i_pins_w3 == PINS_BRAKE) == (i_speed_w3 == '0));

    // duty within full scale, and zero while braking
    assign duty_ok = (i_duty_w0 <= DUTY_FULL) && (i_duty_w1 <= DUTY_FULL)
                  && (i_duty_w2 <= DUTY_FULL) && (i_duty_w3 <= DUTY_FULL)
                  && ((i_pins_w0 != PINS_BRAKE) || (i_duty_w0 == '0))
                  && ((i_pins_w1 != PINS_BRAKE) || (i_duty_w1 == '0))
                  && ((i_pins_w2 != PINS_BRAKE) || (i_duty_w2 == '0))
                  && ((i_pins_w3 != PINS_BRAKE) || (i_duty_w3 == '0));

    // every taken item comes out after the fixed pipeline depth
    `OWDM_ASSERT_DLY(a_item_out, i_clk, i_rst_n, taken, PIPE_DEPTH, i_strobe)

    // no result without an item taken a pipeline depth earlier
    `OWDM_ASSERT_IMP(a_no_extra, i_clk, i_rst_n, i_strobe, $past(taken, PIPE_DEPTH))

    `OWDM_ASSERT_IMP(a_brake_zero, i_clk, i_rst_n, i_strobe, brake_ok)

    `OWDM_ASSERT_IMP(a_duty_range, i_clk, i_rst_n, i_strobe, duty_ok)

endmodule

bind omni_wheel_drive_mixer owdm_checker #(
    .RPM_BITS (RPM_BITS)
) u_owdm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_start    (start),
    .i_busy     (busy),
    .i_strobe   (o_strobe),
    .i_speed_w0 (o_speed_w0),
    .i_speed_w1 (o_speed_w1),
    .i_speed_w2 (o_speed_w2),
    .i_speed_w3 (o_speed_w3),
    .i_duty_w0  (o_duty_w0),
    .i_duty_w1  (o_duty_w1),
    .i_duty_w2  (o_duty_w2),
    .i_duty_w3  (o_duty_w3),
    .i_pins_w0  (o_pins_w0),
    .i_pins_w1  (o_pins_w1),
    .i_pins_w2  (o_pins_w2),
    .i_pins_w3  (o_pins_w3)
);

`default_nettype wire
